>>> design/paqs_pkg.sv
// Package for the per-question answer statistics block.
// Sizes, record layout, command/status structs and function codes.
// No dependencies.
package paqs_pkg;

    localparam int NUM_QUESTIONS  = 64;
    localparam int NUM_CATEGORIES = 8;
    localparam int COUNT_BITS     = 20;

    // port widths fixed by the interface
    localparam int Q_BITS    = 6;
    localparam int ANS_BITS  = 4;
    localparam int CAT_BITS  = 3;
    localparam int QIU_BITS  = 7;
    localparam int MEAN_BITS = 11;
    localparam int SD_BITS   = 11;
    localparam logic [QIU_BITS-1:0] QIU_RESET = QIU_BITS'(64);

    localparam int ADDR_BITS = $clog2(NUM_QUESTIONS);
    localparam int VAL_BITS  = $clog2(NUM_CATEGORIES);
    localparam int SUM_BITS  = COUNT_BITS + VAL_BITS;
    localparam int SQ_BITS   = COUNT_BITS + 2 * VAL_BITS;
    localparam int PROD_BITS = COUNT_BITS + SQ_BITS;
    localparam int FRAC_BITS = 8;
    localparam int X_BITS    = PROD_BITS + 2 * FRAC_BITS;
    localparam int D_BITS    = 2 * COUNT_BITS;

    localparam int MEAN_STEPS = SUM_BITS + FRAC_BITS;
    localparam int VAR_STEPS  = X_BITS;
    localparam int SQ_TOP     = (X_BITS - 1) & ~1;
    localparam int SQRT_STEPS = SQ_TOP / 2 + 1;
    localparam int CNT_BITS   = $clog2(X_BITS);

    localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = '1;

    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef logic [NUM_CATEGORIES-1:0][COUNT_BITS-1:0] t_hist;

    typedef struct packed {
        logic [COUNT_BITS-1:0] cnt;
        logic [SUM_BITS-1:0]   sum;
        logic [SQ_BITS-1:0]    sq;
        t_hist                 hist;
    } t_rec;

    localparam int REC_BITS = $bits(t_rec);

    typedef struct packed {
        logic accept;     // word taken, launch record read
        logic cap;        // record data valid, capture / write back
        logic add_wr;     // write back an add
        logic mean_load;  // load divider for mean
        logic div_step;
        logic var_load;   // take mean, load divider for variance
        logic sqrt_load;
        logic sqrt_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic func;
    } t_sts;

endpackage

>>> design/paqs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module paqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> design/paqs_ctrl.sv
// Sequencer for the statistics block: add write-back, mean division,
// variance division and square root. Uses paqs_pkg.
module paqs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  paqs_pkg::t_sts  i_sts,
    output paqs_pkg::t_cmd  o_cmd,
    output logic            o_busy
);
    import paqs_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DAT  = 3'd1;
    localparam logic [2:0] S_DIVM = 3'd2;
    localparam logic [2:0] S_VLD  = 3'd3;
    localparam logic [2:0] S_DIVV = 3'd4;
    localparam logic [2:0] S_SLD  = 3'd5;
    localparam logic [2:0] S_SQRT = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0]          r_state, n_state;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    t_cmd                cmd;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.accept = 1'b1;
                    n_state    = S_DAT;
                end
            end
            S_DAT: begin
                cmd.cap = 1'b1;
                if (i_sts.func == FUNC_ADD) begin
                    cmd.add_wr = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    cmd.mean_load = 1'b1;
                    n_cnt         = CNT_BITS'(MEAN_STEPS - 1);
                    n_state       = S_DIVM;
                end
            end
            S_DIVM: begin
                cmd.div_step = 1'b1;
                n_cnt        = r_cnt - 1'b1;
                if (r_cnt == '0) n_state = S_VLD;
            end
            S_VLD: begin
                cmd.var_load = 1'b1;
                n_cnt        = CNT_BITS'(VAR_STEPS - 1);
                n_state      = S_DIVV;
            end
            S_DIVV: begin
                cmd.div_step = 1'b1;
                n_cnt        = r_cnt - 1'b1;
                if (r_cnt == '0) n_state = S_SLD;
            end
            S_SLD: begin
                cmd.sqrt_load = 1'b1;
                n_cnt         = CNT_BITS'(SQRT_STEPS - 1);
                n_state       = S_SQRT;
            end
            S_SQRT: begin
                cmd.sqrt_step = 1'b1;
                n_cnt         = r_cnt - 1'b1;
                if (r_cnt == '0) n_state = S_OUT;
            end
            S_OUT: begin
                cmd.out_load = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);

    a_dat_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DAT |-> $past(cmd.accept))
        else $error("record stage without accepted word");
    a_divm_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIVM |-> r_cnt < CNT_BITS'(MEAN_STEPS))
        else $error("mean step count out of range");
    a_sqrt_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SQRT |-> r_cnt < CNT_BITS'(SQRT_STEPS))
        else $error("root step count out of range");
endmodule

>>> design/paqs_dp.sv
// Datapath: record store with per-question valid bits, add update,
// products, shared restoring divider and digit-by-digit square root.
// Uses paqs_pkg and paqs_ram.
module paqs_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  paqs_pkg::t_cmd                   i_cmd,
    output paqs_pkg::t_sts                   o_sts,
    input  logic                             i_cfg_we,
    input  logic [paqs_pkg::QIU_BITS-1:0]    i_cfg_wdata,
    input  logic                             i_func,
    input  logic [paqs_pkg::Q_BITS-1:0]      i_question,
    input  logic [paqs_pkg::ANS_BITS-1:0]    i_answer,
    input  logic [paqs_pkg::CAT_BITS-1:0]    i_category,
    output logic                             o_valid,
    output logic                             o_in_range,
    output logic [paqs_pkg::COUNT_BITS-1:0]  o_answered_count,
    output logic [paqs_pkg::MEAN_BITS-1:0]   o_mean_q8,
    output logic [paqs_pkg::SD_BITS-1:0]     o_sd_q8,
    output logic [paqs_pkg::COUNT_BITS-1:0]  o_bin_count
);
    import paqs_pkg::*;

    logic [QIU_BITS-1:0]      r_qiu;
    logic [NUM_QUESTIONS-1:0] r_qvalid;
    logic                     r_hit;
    logic                     r_func;
    logic [ADDR_BITS-1:0]     r_q;
    logic [ANS_BITS-1:0]      r_ans;
    logic [CAT_BITS-1:0]      r_cat;
    logic                     r_ok;

    logic [REC_BITS-1:0]      ram_rdata;
    t_rec                     rec, new_rec;
    logic                     add_ok;
    logic [VAL_BITS-1:0]      v;

    // query operands
    logic [COUNT_BITS-1:0]    r_n;
    logic [SUM_BITS-1:0]      r_s;
    logic [SQ_BITS-1:0]       r_sq;
    logic [COUNT_BITS-1:0]    r_bin;
    logic [PROD_BITS-1:0]     r_nsq, r_ss;
    logic [D_BITS-1:0]        r_nn1;
    logic [MEAN_BITS-1:0]     r_mean;
    logic                     r_neg;

    // divider
    logic [X_BITS-1:0]        r_x;
    logic [D_BITS-1:0]        r_rem, r_d;
    logic [D_BITS:0]          rem_sh;
    logic                     ge;
    logic [D_BITS:0]          rem_sub;

    // square root
    logic [X_BITS-1:0]        r_v, r_res, r_bit;
    logic [X_BITS-1:0]        trial;

    logic                     r_valid;
    logic                     r_in_range;
    logic [COUNT_BITS-1:0]    r_ocnt, r_obin;
    logic [MEAN_BITS-1:0]     r_omean;
    logic [SD_BITS-1:0]       r_osd;

    paqs_ram #(.WIDTH(REC_BITS), .DEPTH(NUM_QUESTIONS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.add_wr && add_ok),
        .i_waddr (r_q),
        .i_wdata (new_rec),
        .i_re    (i_cmd.accept),
        .i_raddr (ADDR_BITS'(i_question)),
        .o_rdata (ram_rdata)
    );

    // never-written questions read as zero
    assign rec = r_hit ? t_rec'(ram_rdata) : '0;

    always_comb begin
        v       = VAL_BITS'(r_ans - 1'b1);
        add_ok  = r_ok && (r_ans != '0) && (int'(r_ans) <= NUM_CATEGORIES)
                  && (rec.cnt != COUNT_LIMIT);
        new_rec = rec;
        new_rec.cnt     = rec.cnt + 1'b1;
        new_rec.sum     = rec.sum + SUM_BITS'(v);
        new_rec.sq      = rec.sq + SQ_BITS'(v) * SQ_BITS'(v);
        new_rec.hist[v] = rec.hist[v] + 1'b1;
    end

    assign o_sts.func = r_func;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qiu    <= QIU_RESET;
            r_qvalid <= '0;
        end else begin
            if (i_cfg_we) r_qiu <= i_cfg_wdata;
            if (i_cmd.add_wr && add_ok) r_qvalid[r_q] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_hit  <= r_qvalid[ADDR_BITS'(i_question)];
            r_func <= i_func;
            r_q    <= ADDR_BITS'(i_question);
            r_ans  <= i_answer;
            r_cat  <= i_category;
            r_ok   <= ({1'b0, i_question} < r_qiu)
                      && (int'(i_question) < NUM_QUESTIONS);
        end
        if (i_cmd.cap) begin
            r_n   <= rec.cnt;
            r_s   <= rec.sum;
            r_sq  <= rec.sq;
            r_bin <= (int'(r_cat) < NUM_CATEGORIES) ? rec.hist[VAL_BITS'(r_cat)] : '0;
        end
        r_nsq <= PROD_BITS'(r_n) * PROD_BITS'(r_sq);
        r_ss  <= PROD_BITS'(r_s) * PROD_BITS'(r_s);
        r_nn1 <= D_BITS'(r_n) * D_BITS'(r_n - 1'b1);
    end

    // restoring divider, one quotient bit per cycle into the low end of r_x
    always_comb begin
        rem_sh  = {r_rem, r_x[X_BITS-1]};
        ge      = rem_sh >= {1'b0, r_d};
        rem_sub = rem_sh - {1'b0, r_d};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mean_load) begin
            r_x   <= {rec.sum, FRAC_BITS'(0), (X_BITS - MEAN_STEPS)'(0)};
            r_d   <= D_BITS'(rec.cnt);
            r_rem <= '0;
        end else if (i_cmd.var_load) begin
            r_mean <= MEAN_BITS'(r_x);
            r_neg  <= r_nsq < r_ss;
            r_x    <= {PROD_BITS'(r_nsq - r_ss), (2 * FRAC_BITS)'(0)};
            r_d    <= r_nn1;
            r_rem  <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= ge ? D_BITS'(rem_sub) : D_BITS'(rem_sh);
            r_x   <= {r_x[X_BITS-2:0], ge};
        end
    end

    assign trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_load) begin
            r_v   <= r_x;
            r_res <= '0;
            r_bit <= X_BITS'(1) << SQ_TOP;
        end else if (i_cmd.sqrt_step) begin
            if (r_v >= trial) begin
                r_v   <= r_v - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.out_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_in_range <= r_ok;
            r_ocnt     <= r_ok ? r_n : '0;
            r_omean    <= (r_ok && r_n != '0) ? r_mean : '0;
            r_osd      <= (r_ok && r_n >= COUNT_BITS'(2) && !r_neg) ? SD_BITS'(r_res) : '0;
            r_obin     <= r_ok ? r_bin : '0;
        end
    end

    assign o_valid          = r_valid;
    assign o_in_range       = r_in_range;
    assign o_answered_count = r_ocnt;
    assign o_mean_q8        = r_omean;
    assign o_sd_q8          = r_osd;
    assign o_bin_count      = r_obin;

    a_valid_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_cmd.out_load))
        else $error("result strobe without final stage");
    a_sd_needs_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_sd_q8 != '0 |-> o_answered_count >= COUNT_BITS'(2))
        else $error("deviation reported for fewer than two answers");
    a_out_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_in_range |-> o_answered_count == '0 && o_bin_count == '0
                                   && o_mean_q8 == '0)
        else $error("out-of-range query carries data");
endmodule

>>> design/per_question_answer_statistics_top.sv
// Per-question answer statistics: count, mean, sample deviation, histogram.
// Add word: busy while the record is read and then written back, then idle again.
// Query word: busy through a 31-step mean divide, a 62-step variance divide (both on the
// shared divider) and a 31-step square root; o_valid rises in the cycle after the S_OUT state.
// Synchronous active-low reset clears all records (per-question valid bits) and sets
// questions_in_use to 64. Results cannot be stalled. Uses paqs_pkg, paqs_ctrl, paqs_dp.
module per_question_answer_statistics_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_cfg_we,
    input  logic [paqs_pkg::QIU_BITS-1:0]    i_cfg_wdata,
    input  logic                             i_func,
    input  logic [paqs_pkg::Q_BITS-1:0]      i_question,
    input  logic [paqs_pkg::ANS_BITS-1:0]    i_answer,
    input  logic [paqs_pkg::CAT_BITS-1:0]    i_category,
    output logic                             o_valid,
    output logic                             o_in_range,
    output logic [paqs_pkg::COUNT_BITS-1:0]  o_answered_count,
    output logic [paqs_pkg::MEAN_BITS-1:0]   o_mean_q8,
    output logic [paqs_pkg::SD_BITS-1:0]     o_sd_q8,
    output logic [paqs_pkg::COUNT_BITS-1:0]  o_bin_count
);
    import paqs_pkg::*;

    t_cmd cmd;
    t_sts sts;

    paqs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    paqs_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_func           (i_func),
        .i_question       (i_question),
        .i_answer         (i_answer),
        .i_category       (i_category),
        .o_valid          (o_valid),
        .o_in_range       (o_in_range),
        .o_answered_count (o_answered_count),
        .o_mean_q8        (o_mean_q8),
        .o_sd_q8          (o_sd_q8),
        .o_bin_count      (o_bin_count)
    );
endmodule

>>> verif/per_question_answer_statistics_top_tb.sv
// Testbench for per_question_answer_statistics_top: directed and random add/query words,
// a word-level predictor of per-question statistics, and a strobe monitor.
// Depends on paqs_pkg and the design files.
`timescale 1ns / 100ps

module per_question_answer_statistics_top_tb;
    import paqs_pkg::*;

    typedef struct packed {
        logic                func;
        logic [Q_BITS-1:0]   question;
        logic [ANS_BITS-1:0] answer;
        logic [CAT_BITS-1:0] category;
        logic                is_cfg;
        logic                drain;     // wait for idle before this word
        logic [QIU_BITS-1:0] cfg_val;
    } t_word;

    typedef struct packed {
        logic                  in_range;
        logic [COUNT_BITS-1:0] count;
        logic [MEAN_BITS-1:0]  mean;
        logic [SD_BITS-1:0]    sd;
        logic [COUNT_BITS-1:0] bin;
    } t_stats;

    logic i_clk, i_rst_n, start, busy, i_cfg_we, i_func, o_valid, o_in_range;
    logic [QIU_BITS-1:0] i_cfg_wdata;
    logic [Q_BITS-1:0] i_question;
    logic [ANS_BITS-1:0] i_answer;
    logic [CAT_BITS-1:0] i_category;
    logic [COUNT_BITS-1:0] o_answered_count, o_bin_count;
    logic [MEAN_BITS-1:0] o_mean_q8;
    logic [SD_BITS-1:0] o_sd_q8;

    per_question_answer_statistics_top u_top (.*);

    // predictor state
    logic [QIU_BITS-1:0]   pred_qiu;
    logic [COUNT_BITS-1:0] pred_cnt [NUM_QUESTIONS];
    longint unsigned       pred_sum [NUM_QUESTIONS];
    longint unsigned       pred_sq  [NUM_QUESTIONS];
    logic [COUNT_BITS-1:0] pred_hist [NUM_QUESTIONS][NUM_CATEGORIES];

    t_word  pending_words[$];
    t_stats expected_stats[$];
    int     errors = 0;
    bit     stim_done = 0;
    int     gap = 0;
    int     settle = 0;

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned r = 0, b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // apply one word to the model; queries push an expectation
    task automatic predict_word(input t_word w);
        logic ok;
        longint unsigned n, s, sq, v;
        logic [127:0] num;
        t_stats r;
        ok = (w.question < pred_qiu) && (w.question < NUM_QUESTIONS);
        if (w.func == FUNC_ADD) begin
            if (ok && w.answer != 0 && w.answer <= NUM_CATEGORIES
                    && pred_cnt[w.question] != COUNT_LIMIT) begin
                v = 64'(w.answer) - 64'd1;
                pred_cnt[w.question]++;
                pred_sum[w.question] += v;
                pred_sq[w.question]  += v * v;
                pred_hist[w.question][v]++;
            end
            return;
        end
        r = '0;
        if (ok) begin
            n = 64'(pred_cnt[w.question]);
            s = pred_sum[w.question];
            sq = pred_sq[w.question];
            r.in_range = 1;
            r.count = COUNT_BITS'(n);
            if (n != 0) r.mean = MEAN_BITS'((s << 8) / n);
            if (n >= 2 && n * sq >= s * s) begin
                num = 128'(n * sq - s * s) << 16;
                r.sd = SD_BITS'(isqrt(64'(num / 128'(n * (n - 1)))));
            end
            if (w.category < NUM_CATEGORIES) r.bin = pred_hist[w.question][w.category];
        end
        expected_stats.push_back(r);
    endtask

    function automatic t_word make_word(logic f, int q, int a, int c);
        t_word w = '0;
        w.func = f;
        w.question = Q_BITS'(q);
        w.answer = ANS_BITS'(a);
        w.category = CAT_BITS'(c);
        return w;
    endfunction

    function automatic t_word make_cfg(int val);
        t_word w = '0;
        w.is_cfg = 1;
        w.cfg_val = QIU_BITS'(val);
        return w;
    endfunction

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #40ms;
        $display("Some tests failed");
        $finish;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 0;
            i_cfg_we <= 0;
        end else begin
            i_cfg_we <= 0;
            if (start && !busy) begin
                predict_word({i_func, i_question, i_answer, i_category, 1'b0, 1'b0, 7'd0});
            end
            if (start && busy) begin
                // hold
            end else if (gap > 0) begin
                start <= 0;
                gap <= gap - 1;
            end else if (pending_words.size() != 0 && (pending_words[0].is_cfg
                    || pending_words[0].drain) && (busy || start
                    || expected_stats.size() != 0 || settle < 140)) begin
                // idle: let the block finish before config or a drain point
                start <= 0;
                settle <= (busy || start || expected_stats.size() != 0) ? 0 : settle + 1;
            end else if (pending_words.size() != 0) begin
                t_word w;
                w = pending_words.pop_front();
                settle <= 0;
                if (w.is_cfg) begin
                    start <= 0;
                    i_cfg_we <= 1;
                    i_cfg_wdata <= w.cfg_val;
                    pred_qiu <= w.cfg_val;
                end else begin
                    start <= 1;
                    i_func <= w.func;
                    i_question <= w.question;
                    i_answer <= w.answer;
                    i_category <= w.category;
                    if ($urandom_range(0, 3) == 0)
                        gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200)
                                                           : $urandom_range(1, 4);
                end
            end else begin
                start <= 0;
                stim_done <= 1;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            t_stats got, exp_r;
            got = {o_in_range, o_answered_count, o_mean_q8, o_sd_q8, o_bin_count};
            if (expected_stats.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, got);
                errors++;
            end else begin
                exp_r = expected_stats.pop_front();
                if (got.in_range !== exp_r.in_range)
                    $display("%0t: in_range exp %0d got %0d", $time, exp_r.in_range, got.in_range);
                if (got.count !== exp_r.count)
                    $display("%0t: count exp %0d got %0d", $time, exp_r.count, got.count);
                if (got.mean !== exp_r.mean)
                    $display("%0t: mean exp %0d got %0d", $time, exp_r.mean, got.mean);
                if (got.sd !== exp_r.sd)
                    $display("%0t: sd exp %0d got %0d", $time, exp_r.sd, got.sd);
                if (got.bin !== exp_r.bin)
                    $display("%0t: bin exp %0d got %0d", $time, exp_r.bin, got.bin);
                if (got !== exp_r) errors++;
            end
        end
    end

    // random phase for one questions_in_use setting; adds bias toward few questions
    task automatic add_random(int n, int qmax);
        t_word w;
        for (int i = 0; i < n; i++) begin
            int q = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, qmax);
            if ($urandom_range(0, 2) == 0)
                w = make_word(FUNC_QUERY, q, $urandom_range(0, 15), $urandom_range(0, 7));
            else
                w = make_word(FUNC_ADD, q, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                            : $urandom_range(1, 8), $urandom_range(0, 7));
            pending_words.push_back(w);
        end
    endtask

    initial begin
        t_word w;
        pred_qiu = QIU_RESET;
        for (int q = 0; q < NUM_QUESTIONS; q++) begin
            pred_cnt[q] = 0;
            pred_sum[q] = 0;
            pred_sq[q] = 0;
            for (int c = 0; c < NUM_CATEGORIES; c++) pred_hist[q][c] = 0;
        end
        i_rst_n = 0;
        start = 0;
        i_cfg_we = 0;
        i_cfg_wdata = '0;
        i_func = 0;
        i_question = '0;
        i_answer = '0;
        i_category = '0;

        // directed: empty query, one answer, extremes, skipped and too-large answers
        pending_words.push_back(make_word(FUNC_QUERY, 0, 0, 0));
        pending_words.push_back(make_word(FUNC_ADD, 0, 8, 0));
        pending_words.push_back(make_word(FUNC_QUERY, 0, 0, 7));
        pending_words.push_back(make_word(FUNC_ADD, 0, 1, 0));
        pending_words.push_back(make_word(FUNC_ADD, 0, 0, 0));
        pending_words.push_back(make_word(FUNC_ADD, 0, 9, 0));
        pending_words.push_back(make_word(FUNC_ADD, 0, 15, 0));
        pending_words.push_back(make_word(FUNC_QUERY, 0, 15, 0));
        pending_words.push_back(make_word(FUNC_ADD, 63, 8, 7));
        pending_words.push_back(make_word(FUNC_ADD, 63, 8, 7));
        pending_words.push_back(make_word(FUNC_QUERY, 63, 0, 7));
        pending_words.push_back(make_word(FUNC_QUERY, 63, 0, 0));
        w = make_word(FUNC_QUERY, 0, 0, 0);
        w.drain = 1;
        pending_words.push_back(w);
        // out-of-range add and query at a setting of one question
        pending_words.push_back(make_cfg(1));
        pending_words.push_back(make_word(FUNC_ADD, 1, 3, 0));
        pending_words.push_back(make_word(FUNC_QUERY, 1, 0, 2));
        pending_words.push_back(make_word(FUNC_QUERY, 0, 0, 7));
        add_random(200, 0);
        pending_words.push_back(make_cfg(127));
        add_random(400, 63);
        pending_words.push_back(make_cfg(33));
        add_random(400, 40);
        pending_words.push_back(make_cfg(64));
        add_random(600, 7);
        pending_words.push_back(make_cfg(0));
        add_random(30, 63);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        wait (stim_done);
        while (expected_stats.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

>>> sim.f
design/paqs_pkg.sv
design/paqs_ram.sv
design/paqs_ctrl.sv
design/paqs_dp.sv
design/per_question_answer_statistics_top.sv
verif/per_question_answer_statistics_top_tb.sv
